// File: hw/rtl/pcpt_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helpers for the pin-change pulse timestamper.
package pcpt_pkg;

  // Port and pin geometry; the port count follows from the port field width
  localparam int PORT_W      = 2;
  localparam int PINS        = 8;
  localparam int PIN_W       = 3;
  localparam int NUM_PORTS   = 1 << PORT_W;
  localparam int NUM_SENSORS = NUM_PORTS * PINS;
  localparam int SENSOR_W    = PORT_W + PIN_W;

  // Timer and history geometry
  localparam int TIME_W       = 16;
  localparam int HIST_DEPTH   = 4;
  localparam int OUT_ENTRIES  = 4;
  localparam int RISE_ROW_W   = PINS * TIME_W;
  localparam int HIST_ROW_W   = HIST_DEPTH * TIME_W;

  localparam logic [TIME_W-1:0] MIN_HIGH_RESET = TIME_W'(8);

  typedef logic [PINS-1:0][TIME_W-1:0]       rise_row_t;
  typedef logic [HIST_DEPTH-1:0][TIME_W-1:0] hist_row_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RISE  = 4'b0010,
    S_HREAD = 4'b0100,
    S_HEVAL = 4'b1000
  } state_e;

  // High time with 16-bit wrap
  function automatic logic [TIME_W-1:0] period_of(logic [TIME_W-1:0] now,
                                                  logic [TIME_W-1:0] rise);
    period_of = now - rise;
  endfunction

  // Index of the lowest set bit, zero when none is set
  function automatic logic [PIN_W-1:0] lowest_pin(logic [PINS-1:0] mask);
    logic [PIN_W-1:0] idx;
    idx = '0;
    for (int p = PINS - 1; p >= 0; p--) begin
      if (mask[p]) begin
        idx = PIN_W'(p);
      end
    end
    lowest_pin = idx;
  endfunction

endpackage

// File: hw/rtl/pcpt_ifs.sv
`timescale 1ns / 1ps
// Channel interfaces for port samples, timestamp results and configuration.

interface pcpt_smp_if;
  import pcpt_pkg::*;
  logic                valid;
  logic                ready;
  logic [PORT_W-1:0]   port_select;
  logic [PINS-1:0]     pin_levels;
  logic [TIME_W-1:0]   timer_now;
  logic [PINS-1:0]     read_lock_mask;
  modport source (output valid, port_select, pin_levels, timer_now, read_lock_mask,
                  input ready);
  modport sink   (input valid, port_select, pin_levels, timer_now, read_lock_mask,
                  output ready);
endinterface

interface pcpt_res_if;
  import pcpt_pkg::*;
  logic                valid;
  logic                ready;
  logic [SENSOR_W-1:0] sensor_index;
  logic [TIME_W-1:0]   newest_time;
  logic [TIME_W-1:0]   older_time_1;
  logic [TIME_W-1:0]   older_time_2;
  logic [TIME_W-1:0]   older_time_3;
  logic [TIME_W-1:0]   pulse_ticks;
  logic                last;
  modport source (output valid, sensor_index, newest_time, older_time_1, older_time_2,
                  older_time_3, pulse_ticks, last, input ready);
  modport sink   (input valid, sensor_index, newest_time, older_time_1, older_time_2,
                  older_time_3, pulse_ticks, last, output ready);
endinterface

interface pcpt_cfg_if;
  import pcpt_pkg::*;
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] min_high_period;
  modport source (output valid, min_high_period, input ready);
  modport sink   (input valid, min_high_period, output ready);
endinterface

// File: hw/rtl/pcpt_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module pcpt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/pin_change_pulse_timestamper_unit.sv
`timescale 1ns / 1ps
// Top level of the pin-change pulse timestamper.
//
//   channel  dir  transaction
//   -------  ---  ----------------------------------------------------------
//   smp_i    in   port sample: port, pin levels, timer value, read-lock mask
//   res_o    out  one qualifying falling pin: sensor, history, high time, last
//   cfg_i    in   write of min_high_period
//
// An item goes through a level compare, then a read-modify-write of the port's
// rise-time row, then a read and write-back of each qualifying falling pin's
// history row in the history RAM.
// Reset clears the port levels, the row valid bits and sets min_high_period to
// 8; rows never written read as zero, so there is no clearing pass.
// A stalled result holds the sequencer; new samples are taken only when idle.
module pin_change_pulse_timestamper_unit
  import pcpt_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  pcpt_smp_if.sink     smp_i,
  pcpt_res_if.source   res_o,
  pcpt_cfg_if.sink     cfg_i
);

  state_e               state_q, state_d;
  logic [PORT_W-1:0]    port_q;
  logic [TIME_W-1:0]    now_q;
  logic [PINS-1:0]      rising_q, falling_q, lock_q;
  logic [PINS-1:0]      pend_q, pend_d;
  logic [PIN_W-1:0]     pin_q, pin_d;
  logic [TIME_W-1:0]    min_q;
  logic [PINS-1:0]      levels_q [NUM_PORTS];
  logic [NUM_PORTS-1:0] rise_vld_q;
  logic [NUM_SENSORS-1:0] hist_vld_q;
  rise_row_t            rise_row_q;

  logic                 out_vld_q;
  logic [SENSOR_W-1:0]  out_sid_q;
  hist_row_t            out_row_q;
  logic [TIME_W-1:0]    out_period_q;
  logic                 out_last_q;
  logic [OUT_ENTRIES-1:0][TIME_W-1:0] out_ent;

  logic                 smp_acc;
  logic                 out_free;
  logic                 out_load;
  logic [PINS-1:0]      changed;
  logic [PIN_W-1:0]     sel_pin;
  logic [PINS-1:0]      rest;
  logic [SENSOR_W-1:0]  sid;

  logic [RISE_ROW_W-1:0] rise_rdata;
  rise_row_t            rise_old, rise_new;
  logic [PINS-1:0]      qual;
  logic                 rise_we;

  logic [HIST_ROW_W-1:0] hist_rdata;
  hist_row_t            hist_old, hist_new;
  logic                 hist_re;

  // Handshakes
  assign smp_i.ready = (state_q == S_IDLE);
  assign smp_acc     = smp_i.valid & smp_i.ready;
  assign cfg_i.ready = 1'b1;
  assign out_free    = ~out_vld_q | res_o.ready;

  // Compare the sample with the port's last levels
  assign changed = smp_i.pin_levels ^ levels_q[smp_i.port_select];

  // Rise-time rows, one per port
  pcpt_ram #(
    .WIDTH (RISE_ROW_W),
    .DEPTH (NUM_PORTS)
  ) u_rise_ram (
    .clk_i   (clk_i),
    .we_i    (rise_we),
    .waddr_i (port_q),
    .wdata_i (rise_new),
    .re_i    (smp_acc),
    .raddr_i (smp_i.port_select),
    .rdata_o (rise_rdata)
  );

  // Merge rising pins into the row and find the falling pins that qualify
  assign rise_we = (state_q == S_RISE);
  always_comb begin
    rise_old = rise_vld_q[port_q] ? rise_row_t'(rise_rdata) : '0;
    for (int p = 0; p < PINS; p++) begin
      rise_new[p] = rising_q[p] ? now_q : rise_old[p];
      qual[p]     = falling_q[p] & ~lock_q[p] &
                    (period_of(now_q, rise_old[p]) > min_q);
    end
  end

  // History rows, one per sensor
  assign sel_pin = lowest_pin(pend_q);
  assign hist_re = (state_q == S_HREAD);
  assign sid     = {port_q, (state_q == S_HREAD) ? sel_pin : pin_q};
  assign out_load = (state_q == S_HEVAL) & out_free;

  pcpt_ram #(
    .WIDTH (HIST_ROW_W),
    .DEPTH (NUM_SENSORS)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (out_load),
    .waddr_i (sid),
    .wdata_i (hist_new),
    .re_i    (hist_re),
    .raddr_i (sid),
    .rdata_o (hist_rdata)
  );

  // Shift the history and put the fall time in front
  always_comb begin
    hist_old    = hist_vld_q[sid] ? hist_row_t'(hist_rdata) : '0;
    hist_new[0] = now_q;
    for (int k = 1; k < HIST_DEPTH; k++) begin
      hist_new[k] = hist_old[k-1];
    end
  end

  assign rest = pend_q & ~(PINS'(1) << pin_q);

  // Sequencer
  always_comb begin
    state_d = state_q;
    pend_d  = pend_q;
    pin_d   = pin_q;
    case (state_q)
      S_IDLE: begin
        if (smp_acc) begin
          state_d = S_RISE;
        end
      end
      S_RISE: begin
        pend_d  = qual;
        state_d = (qual == '0) ? S_IDLE : S_HREAD;
      end
      S_HREAD: begin
        pin_d   = sel_pin;
        state_d = S_HEVAL;
      end
      S_HEVAL: begin
        if (out_free) begin
          pend_d  = rest;
          state_d = (rest == '0) ? S_IDLE : S_HREAD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      pend_q     <= '0;
      min_q      <= MIN_HIGH_RESET;
      rise_vld_q <= '0;
      hist_vld_q <= '0;
      out_vld_q  <= 1'b0;
      for (int i = 0; i < NUM_PORTS; i++) begin
        levels_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      if (cfg_i.valid && cfg_i.ready) begin
        min_q <= cfg_i.min_high_period;
      end
      if (smp_acc) begin
        levels_q[smp_i.port_select] <= smp_i.pin_levels;
      end
      if (rise_we) begin
        rise_vld_q[port_q] <= 1'b1;
      end
      if (out_load) begin
        hist_vld_q[sid] <= 1'b1;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Item and result payload registers
  always_ff @(posedge clk_i) begin
    pin_q <= pin_d;
    if (smp_acc) begin
      port_q    <= smp_i.port_select;
      now_q     <= smp_i.timer_now;
      lock_q    <= smp_i.read_lock_mask;
      rising_q  <= changed & smp_i.pin_levels;
      falling_q <= changed & ~smp_i.pin_levels;
    end
    if (rise_we) begin
      rise_row_q <= rise_old;
    end
    if (out_load) begin
      out_sid_q    <= sid;
      out_row_q    <= hist_new;
      out_period_q <= period_of(now_q, rise_row_q[pin_q]);
      out_last_q   <= (rest == '0);
    end
  end

  // Map history entries onto the four output slots
  for (genvar k = 0; k < OUT_ENTRIES; k++) begin : g_ent
    if (k < HIST_DEPTH) begin : g_used
      assign out_ent[k] = out_row_q[k];
    end else begin : g_zero
      assign out_ent[k] = '0;
    end
  end

  assign res_o.valid        = out_vld_q;
  assign res_o.sensor_index = out_sid_q;
  assign res_o.newest_time  = out_ent[0];
  assign res_o.older_time_1 = out_ent[1];
  assign res_o.older_time_2 = out_ent[2];
  assign res_o.older_time_3 = out_ent[3];
  assign res_o.pulse_ticks  = out_period_q;
  assign res_o.last         = out_last_q;

`ifndef SYNTHESIS
  // Pending pins are always a subset of this item's falling pins
  a_pend_subset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q & ~falling_q) == '0)
    else $error("pending pin that did not fall");

  // The pin being evaluated is still pending
  a_pin_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HEVAL) |-> pend_q[pin_q])
    else $error("evaluated pin not pending");

  // A sample transaction is followed by the rise-row update
  a_accept_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    smp_acc |=> (state_q == S_RISE))
    else $error("rise row not updated after sample");

  // A result is loaded only after the history row was read
  a_load_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> ($past(state_q) == S_HREAD) || ($past(state_q) == S_HEVAL))
    else $error("result loaded without history read");
`endif

endmodule

// File: dv/pin_change_pulse_timestamper_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the pin-change pulse timestamper: samples in, pulse stamps out.
module pin_change_pulse_timestamper_unit_test;
  import pcpt_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_OFF_LEN  = 300;
  localparam int STALL_LIMIT   = 3000;

  typedef struct packed {
    logic [PORT_W-1:0] port;
    logic [PINS-1:0]   levels;
    logic [TIME_W-1:0] timer;
    logic [PINS-1:0]   lock;
  } sample_t;

  typedef struct packed {
    logic [SENSOR_W-1:0] sensor;
    logic [TIME_W-1:0]   newest;
    logic [TIME_W-1:0]   older1;
    logic [TIME_W-1:0]   older2;
    logic [TIME_W-1:0]   older3;
    logic [TIME_W-1:0]   width;
    logic                last;
  } stamp_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  pcpt_smp_if smp_ch ();
  pcpt_res_if res_ch ();
  pcpt_cfg_if cfg_ch ();

  pin_change_pulse_timestamper_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .smp_i  (smp_ch),
    .res_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  // Predicted block state
  logic [TIME_W-1:0] glitch_limit;
  logic [PINS-1:0]   levels_seen [NUM_PORTS];
  logic [TIME_W-1:0] rise_at     [NUM_SENSORS];
  logic [TIME_W-1:0] stamp_hist  [NUM_SENSORS][HIST_DEPTH];

  sample_t pending_samples [$];
  stamp_t  expected_stamps [$];
  int      mismatch_count = 0;

  // Traffic shaping, changed by the sequencer at falling edges only
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int hold_off_req   = 0;
  int hold_off_taken = 0;
  int hold_off_left  = 0;

  // Stimulus generator view of each port's levels and of the timer
  logic [PINS-1:0]   gen_levels [NUM_PORTS];
  logic [TIME_W-1:0] gen_ticks;

  int idle_cycles = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [TIME_W-1:0] history_at(int id, int k);
    return (k < HIST_DEPTH) ? stamp_hist[id][k] : '0;
  endfunction

  // Update predicted state for one accepted sample and queue its stamps
  function automatic void stamp_sample(sample_t s);
    logic [PINS-1:0]   changed;
    logic [PINS-1:0]   rising;
    logic [PINS-1:0]   falling;
    logic [TIME_W-1:0] high_ticks;
    stamp_t            burst [$];
    stamp_t            st;
    int                id;
    changed = s.levels ^ levels_seen[s.port];
    rising  = changed & s.levels;
    falling = changed & ~s.levels;
    levels_seen[s.port] = s.levels;
    for (int p = 0; p < PINS; p++) begin
      if (rising[p]) begin
        rise_at[int'(s.port) * PINS + p] = s.timer;
      end
    end
    for (int p = 0; p < PINS; p++) begin
      id = int'(s.port) * PINS + p;
      high_ticks = s.timer - rise_at[id];
      if (falling[p] && !s.lock[p] && high_ticks > glitch_limit) begin
        for (int k = HIST_DEPTH - 1; k > 0; k--) begin
          stamp_hist[id][k] = stamp_hist[id][k-1];
        end
        stamp_hist[id][0] = s.timer;
        st.sensor = SENSOR_W'(id);
        st.newest = history_at(id, 0);
        st.older1 = history_at(id, 1);
        st.older2 = history_at(id, 2);
        st.older3 = history_at(id, 3);
        st.width  = high_ticks;
        st.last   = 1'b0;
        burst.push_back(st);
      end
    end
    if (burst.size() > 0) begin
      burst[burst.size()-1].last = 1'b1;
    end
    foreach (burst[i]) begin
      expected_stamps.push_back(burst[i]);
    end
  endfunction

  function automatic void check_field(string name, logic [TIME_W-1:0] exp_v,
                                      logic [TIME_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  // Drive samples from the pending queue, predicting each accepted one
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      smp_ch.valid <= 1'b0;
    end else begin
      if (smp_ch.valid && smp_ch.ready) begin
        stamp_sample(sample_t'{smp_ch.port_select, smp_ch.pin_levels, smp_ch.timer_now,
                               smp_ch.read_lock_mask});
      end
      if (!smp_ch.valid || smp_ch.ready) begin
        if (pending_samples.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          sample_t s;
          s = pending_samples.pop_front();
          smp_ch.valid          <= 1'b1;
          smp_ch.port_select    <= s.port;
          smp_ch.pin_levels     <= s.levels;
          smp_ch.timer_now      <= s.timer;
          smp_ch.read_lock_mask <= s.lock;
        end else begin
          smp_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Take stamps, checking each against the oldest prediction
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_stamps.size() == 0) begin
          $display("%0t: unexpected stamp, expected none, actual sensor %0d", $time,
                   res_ch.sensor_index);
          mismatch_count++;
        end else begin
          stamp_t e;
          e = expected_stamps.pop_front();
          check_field("sensor_index", TIME_W'(e.sensor), TIME_W'(res_ch.sensor_index));
          check_field("newest_time", e.newest, res_ch.newest_time);
          check_field("older_time_1", e.older1, res_ch.older_time_1);
          check_field("older_time_2", e.older2, res_ch.older_time_2);
          check_field("older_time_3", e.older3, res_ch.older_time_3);
          check_field("pulse_ticks", e.width, res_ch.pulse_ticks);
          check_field("last", TIME_W'(e.last), TIME_W'(res_ch.last));
        end
      end
      if (hold_off_req != hold_off_taken) begin
        hold_off_taken = hold_off_req;
        hold_off_left  = HOLD_OFF_LEN;
      end
      if (hold_off_left > 0) begin
        hold_off_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
      end
    end
  end

  // End the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((smp_ch.valid && smp_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic queue_sample(int port, int levels, int timer, int lock);
    gen_levels[port] = PINS'(levels);
    pending_samples.push_back(sample_t'{PORT_W'(port), PINS'(levels), TIME_W'(timer),
                                        PINS'(lock)});
  endtask

  // Mostly toggles on a moving timer; some repeats, jumps and locked pins
  task automatic queue_random_samples(int n);
    int port;
    int lv;
    int lock;
    int pick;
    for (int i = 0; i < n; i++) begin
      port = $urandom_range(0, NUM_PORTS - 1);
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        lv = gen_levels[port];
      end else if (pick < 20) begin
        lv = $urandom_range(0, 255);
      end else begin
        lv = gen_levels[port] ^ ($urandom_range(0, 255) & $urandom_range(0, 255));
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        gen_ticks += TIME_W'($urandom_range(0, 400));
      end else if (pick < 90) begin
        gen_ticks += TIME_W'($urandom_range(0, 65535));
      end else begin
        gen_ticks += TIME_W'($urandom_range(0, 12));
      end
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        lock = 0;
      end else if (pick < 80) begin
        lock = $urandom_range(0, 255);
      end else if (pick < 95) begin
        lock = 1 << $urandom_range(0, PINS - 1);
      end else begin
        lock = 8'hFF;
      end
      queue_sample(port, lv, gen_ticks, lock);
    end
  endtask

  // Wait until every sample is taken and every stamp has come, then settle
  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_samples.size() != 0 || smp_ch.valid || expected_stamps.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_glitch_limit(logic [TIME_W-1:0] value);
    @(posedge clk_i);
    cfg_ch.valid           <= 1'b1;
    cfg_ch.min_high_period <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    glitch_limit = value;
  endtask

  task automatic run_phase(int src_pct, int sink_pct, int limit, int n, bit hold_off);
    write_glitch_limit(TIME_W'(limit));
    @(negedge clk_i);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    if (hold_off) begin
      hold_off_req++;
    end
    queue_random_samples(n);
    wait_drained();
  endtask

  initial begin
    rst_ni                = 1'b0;
    smp_ch.valid          = 1'b0;
    smp_ch.port_select    = '0;
    smp_ch.pin_levels     = '0;
    smp_ch.timer_now      = '0;
    smp_ch.read_lock_mask = '0;
    res_ch.ready          = 1'b0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.min_high_period = '0;
    glitch_limit          = MIN_HIGH_RESET;
    foreach (levels_seen[i]) begin
      levels_seen[i] = '0;
      gen_levels[i]  = '0;
    end
    foreach (rise_at[i]) begin
      rise_at[i] = '0;
      for (int k = 0; k < HIST_DEPTH; k++) begin
        stamp_hist[i][k] = '0;
      end
    end
    gen_ticks = TIME_W'($urandom);

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: threshold boundary, all pins at once, locks, timer wrap, history shift
    queue_sample(0, 8'hFF, 100, 8'h00);
    queue_sample(0, 8'h00, 108, 8'h00);     // high time equal to limit: dropped
    queue_sample(0, 8'hFF, 200, 8'h00);
    queue_sample(0, 8'h00, 209, 8'h00);     // eight stamps in one sample
    queue_sample(0, 8'h01, 300, 8'hFF);     // locked rise still records
    queue_sample(0, 8'h00, 400, 8'hFF);     // locked fall: skipped
    queue_sample(0, 8'h01, 500, 8'h00);
    queue_sample(0, 8'h00, 600, 8'h00);
    queue_sample(0, 8'h01, 700, 8'h00);
    queue_sample(0, 8'h00, 800, 8'h00);
    queue_sample(0, 8'h01, 900, 8'h00);
    queue_sample(0, 8'h00, 1000, 8'h00);    // history filled to its depth
    queue_sample(1, 8'hFF, 16'hFFF0, 8'h00);
    queue_sample(1, 8'h00, 16'h0010, 8'hAA); // wrapped high time, odd pins locked
    queue_sample(1, 8'h00, 16'h0020, 8'h00); // no change
    queue_sample(2, 8'h80, 16'hFFFF, 8'h00);
    queue_sample(2, 8'h00, 16'h0000, 8'h00); // one tick high: glitch
    queue_sample(2, 8'h80, 16'h0000, 8'h00);
    queue_sample(2, 8'h00, 16'hFFFF, 8'h00); // longest high time
    queue_sample(3, 8'hFF, 16'h1234, 8'h00);
    queue_sample(3, 8'h00, 16'h5678, 8'h55);
    queue_sample(3, 8'hAA, 16'h6000, 8'h00);
    queue_sample(3, 8'h55, 16'h7000, 8'h00); // rise and fall in one sample
    queue_sample(3, 8'h00, 16'h8000, 8'h00);
    wait_drained();

    // Random phases across idle patterns and glitch limits
    run_phase(0, 0, 0, 40, 1'b1);
    run_phase(65, 0, $urandom_range(1, 200), 40, 1'b0);
    run_phase(0, 65, $urandom_range(1, 200), 40, 1'b0);
    run_phase(16, 16, $urandom_range(20000, 40000), 35, 1'b0);
    run_phase(0, 0, 65535, 12, 1'b0);
    run_phase(16, 16, 8, 35, 1'b0);

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
